// ----- hdl/gasc_pkg.sv -----
// Glyph atlas slot cache: shared field widths, status codes and register indexes.
// No dependencies; the interfaces, the top level and the testbench import this package.
package gasc_pkg;

  // Field widths of the channels and registers
  localparam int unsigned GLYPH_W    = 12;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned TEX_W      = 14;
  localparam int unsigned CELL_W     = 9;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // Largest glyph number the input field can carry
  localparam int unsigned GLYPH_MAX  = (1 << GLYPH_W) - 1;

  // Register reset values
  localparam logic [TEX_W-1:0]  TEX_W_RST    = TEX_W'(256);
  localparam logic [CELL_W-1:0] CELL_W_RST   = CELL_W'(16);
  localparam logic [CELL_W-1:0] CELL_H_RST   = CELL_W'(16);
  localparam logic [CNT_W-1:0]  SLOT_LIM_RST = CNT_W'(256);

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_FAIL = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH  = 2'd0,
    REG_CELL_WIDTH = 2'd1,
    REG_CELL_HEIGHT = 2'd2,
    REG_SLOT_LIMIT = 2'd3
  } cfg_reg_e;

endpackage

// ----- hdl/gasc_if.sv -----
// Valid/ready channel interfaces of the glyph atlas slot cache.
// Depends on gasc_pkg for the field widths.

// Lookup request: glyph number and render outcome
interface gasc_in_if import gasc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [GLYPH_W-1:0] glyph_index;
  logic               render_ok;

  modport source (output valid, output glyph_index, output render_ok, input ready);
  modport sink   (input valid, input glyph_index, input render_ok, output ready);
endinterface

// Lookup result: status, atlas cell and its texel position
interface gasc_out_if import gasc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [POS_W-1:0]      x_pos;
  logic [POS_W-1:0]      y_pos;

  modport source (output valid, output status, output slot, output x_pos, output y_pos,
                  input ready);
  modport sink   (input valid, input status, input slot, input x_pos, input y_pos,
                  output ready);
endinterface

// ----- hdl/gasc_slot_table.sv -----
// Glyph slot table: single-port-write, single-port-read synchronous memory.
// One entry per table index; read data is registered.
module gasc_slot_table #(
  parameter int unsigned DEPTH   = 4096,
  parameter int unsigned ENTRY_W = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [ENTRY_W-1:0]       wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [ENTRY_W-1:0]       rdata_o
);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/gasc_divider.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
// Standalone; results hold until the next start.
module gasc_divider #(
  parameter int unsigned DIVIDEND_W = 14,
  parameter int unsigned DIVISOR_W  = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [DIVISOR_W-1:0]  remainder_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dsr_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  // Bring down the next dividend bit and trial-subtract
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    fits    = ~diff[DIVISOR_W+1];
  end

  // Iterate: load on start, then one step a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIVIDEND_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
        rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- hdl/glyph_atlas_slot_cache_unit.sv -----
// Glyph atlas slot cache, top level. Uses gasc_pkg, gasc_if, gasc_slot_table, gasc_divider.
// Looks a glyph up in a direct-mapped slot table and reports its atlas cell and position.
//
// After reset the slot table is swept clean, one entry a cycle, over all INDEX_COUNT entries,
// followed by a per-line recompute; no lookup is taken meanwhile, but register writes are.
// One lookup is in flight at a time. A hit or an insertion passes through the bit-serial
// divider, which splits the cell number into row and column, between transfer in and
// result; a full or render-failed result skips the divider. A write to texture_width or
// cell_width costs one more divider pass before the next lookup is taken. The result sits
// in an output register, so the next request is taken while the last result waits.
module glyph_atlas_slot_cache_unit import gasc_pkg::*; #(
  parameter int unsigned INDEX_COUNT = 4096,
  parameter int unsigned SLOT_COUNT  = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gasc_in_if.sink               glyph_i,
  gasc_out_if.source            place_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW   = $clog2(INDEX_COUNT);
  localparam int unsigned SlotW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned DivW   = (SlotW > TEX_W) ? SlotW : TEX_W;
  localparam int unsigned EntW   = SlotW + 1;
  localparam int unsigned CapLim = (SLOT_COUNT > ((1 << CNT_W) - 1)) ?
                                   ((1 << CNT_W) - 1) : SLOT_COUNT;
  localparam logic [CNT_W-1:0] SlotCap  = CNT_W'(CapLim);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(INDEX_COUNT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PERLINE,
    S_LOOKUP,
    S_DIVIDE,
    S_EMIT
  } state_e;

  // Control and configuration registers
  state_e                state_q;
  logic [IdxW-1:0]       clr_q;
  logic                  pl_dirty_q;
  logic [TEX_W-1:0]      per_line_q;
  logic [CNT_W-1:0]      count_q;
  logic [TEX_W-1:0]      tex_w_q;
  logic [CELL_W-1:0]     cell_w_q;
  logic [CELL_W-1:0]     cell_h_q;
  logic [CNT_W-1:0]      slot_lim_q;

  // Item in flight
  logic [IdxW-1:0]       idx_q;
  logic                  ok_q;
  status_e               res_status_q;
  logic [SlotW-1:0]      res_slot_q;
  logic                  res_zero_q;

  // Output register
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [POS_W-1:0]      out_x_q;
  logic [POS_W-1:0]      out_y_q;

  // Datapath signals
  logic [GLYPH_W-1:0]    glyph_rem;
  logic [IdxW-1:0]       idx_in;
  logic                  in_xfer;
  logic                  geom_we;
  logic [EntW-1:0]       rd_entry;
  logic                  hit;
  logic                  full;
  logic                  insert;
  logic [CNT_W-1:0]      limit;
  logic [SlotW-1:0]      new_slot;
  logic [SlotW-1:0]      hit_slot;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [EntW-1:0]       mem_wdata;
  logic                  div_start;
  logic [DivW-1:0]       div_dividend;
  logic [TEX_W-1:0]      div_divisor;
  logic                  div_done;
  logic [DivW-1:0]       div_quo;
  logic [TEX_W-1:0]      div_rem;
  logic                  emit_go;
  logic [POS_W+CELL_W-1:0] x_prod;
  logic [POS_W+CELL_W-1:0] y_prod;

  // Reduce the glyph number modulo the table depth by scaled compare-subtract
  always_comb begin
    glyph_rem = glyph_i.glyph_index;
    for (int k = 7; k >= 0; k--) begin
      if ((INDEX_COUNT << k) <= GLYPH_MAX) begin
        if (glyph_rem >= GLYPH_W'(INDEX_COUNT << k)) begin
          glyph_rem = glyph_rem - GLYPH_W'(INDEX_COUNT << k);
        end
      end
    end
    idx_in = IdxW'(glyph_rem);
  end

  assign glyph_i.ready = (state_q == S_IDLE) && !pl_dirty_q;
  assign in_xfer       = glyph_i.valid && glyph_i.ready;

  // A width write makes the per-line count stale
  assign geom_we = cfg_we_i && (cfg_idx_i inside {REG_TEX_WIDTH, REG_CELL_WIDTH});

  // Lookup decision on the table entry read back
  always_comb begin
    limit    = (slot_lim_q > SlotCap) ? SlotCap : slot_lim_q;
    hit_slot = rd_entry[SlotW-1:0];
    new_slot = SlotW'(count_q);
    hit      = rd_entry[EntW-1];
    full     = (count_q >= limit);
    insert   = !hit && !full && ok_q;
  end

  // Table write: clearing sweep, or a new entry on insertion
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {1'b1, new_slot};
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_LOOKUP && insert) begin
      mem_we = 1'b1;
    end
  end

  gasc_slot_table #(
    .DEPTH   (INDEX_COUNT),
    .ENTRY_W (EntW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_xfer),
    .raddr_i (idx_in),
    .rdata_o (rd_entry)
  );

  // Divider operands: per-line count when idle, cell split during a lookup
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DivW'(tex_w_q);
    div_divisor  = TEX_W'(cell_w_q);
    if (state_q == S_IDLE && pl_dirty_q) begin
      div_start = 1'b1;
    end else if (state_q == S_LOOKUP) begin
      div_start    = hit || insert;
      div_dividend = hit ? DivW'(hit_slot) : DivW'(new_slot);
      div_divisor  = per_line_q;
    end
  end

  gasc_divider #(
    .DIVIDEND_W (DivW),
    .DIVISOR_W  (TEX_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Texel position from column and row; wraps to the position width
  always_comb begin
    x_prod  = {CELL_W'(0), POS_W'(div_rem)} * {POS_W'(0), cell_w_q};
    y_prod  = {CELL_W'(0), POS_W'(div_quo)} * {POS_W'(0), cell_h_q};
    emit_go = (state_q == S_EMIT) && (!out_valid_q || place_o.ready);
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      pl_dirty_q   <= 1'b1;
      per_line_q   <= TEX_W'(1);
      count_q      <= '0;
      tex_w_q      <= TEX_W_RST;
      cell_w_q     <= CELL_W_RST;
      cell_h_q     <= CELL_H_RST;
      slot_lim_q   <= SLOT_LIM_RST;
      idx_q        <= '0;
      ok_q         <= 1'b0;
      res_status_q <= ST_HIT;
      res_slot_q   <= '0;
      res_zero_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_x_q      <= '0;
      out_y_q      <= '0;
    end else begin
      // Register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_TEX_WIDTH:   tex_w_q    <= cfg_data_i[TEX_W-1:0];
          REG_CELL_WIDTH:  cell_w_q   <= cfg_data_i[CELL_W-1:0];
          REG_CELL_HEIGHT: cell_h_q   <= cfg_data_i[CELL_W-1:0];
          REG_SLOT_LIMIT:  slot_lim_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end

      // Mark the per-line count stale on a width write; clear the mark as the recompute starts
      if (geom_we) begin
        pl_dirty_q <= 1'b1;
      end else if (state_q == S_IDLE) begin
        pl_dirty_q <= 1'b0;
      end

      // Load the output on emit, drop it once transferred
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (place_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IdxW'(1);
          if (clr_q == LastIdx) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pl_dirty_q) begin
            state_q <= S_PERLINE;
          end else if (in_xfer) begin
            idx_q   <= idx_in;
            ok_q    <= glyph_i.render_ok;
            state_q <= S_LOOKUP;
          end
        end
        S_PERLINE: begin
          if (div_done) begin
            if (cell_w_q == '0 || div_quo == '0) begin
              per_line_q <= TEX_W'(1);
            end else begin
              per_line_q <= TEX_W'(div_quo);
            end
            state_q <= S_IDLE;
          end
        end
        S_LOOKUP: begin
          if (hit) begin
            res_status_q <= ST_HIT;
            res_slot_q   <= hit_slot;
            res_zero_q   <= 1'b0;
            state_q      <= S_DIVIDE;
          end else if (full) begin
            res_status_q <= ST_FULL;
            res_slot_q   <= '0;
            res_zero_q   <= 1'b1;
            state_q      <= S_EMIT;
          end else if (!ok_q) begin
            res_status_q <= ST_FAIL;
            res_slot_q   <= '0;
            res_zero_q   <= 1'b1;
            state_q      <= S_EMIT;
          end else begin
            res_status_q <= ST_NEW;
            res_slot_q   <= new_slot;
            res_zero_q   <= 1'b0;
            count_q      <= count_q + CNT_W'(1);
            state_q      <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_status_q <= res_status_q;
            out_slot_q   <= SLOT_OUT_W'(res_slot_q);
            out_x_q      <= res_zero_q ? '0 : x_prod[POS_W-1:0];
            out_y_q      <= res_zero_q ? '0 : y_prod[POS_W-1:0];
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign place_o.valid  = out_valid_q;
  assign place_o.status = out_status_q;
  assign place_o.slot   = out_slot_q;
  assign place_o.x_pos  = out_x_q;
  assign place_o.y_pos  = out_y_q;

endmodule

// ----- sim/glyph_atlas_slot_cache_unit_test.sv -----
// Self-checking testbench for glyph_atlas_slot_cache_unit: lookups, inserts and positions
// are checked against a slot table kept in the bench. Needs gasc_pkg, gasc_if and the RTL.
module glyph_atlas_slot_cache_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gasc_pkg::*;

  localparam int unsigned INDEX_COUNT  = 4096;
  localparam int unsigned SLOT_COUNT   = 1024;
  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_COUNT  = 12;
  localparam int unsigned PHASE_ITEMS  = 150;

  typedef struct packed {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [POS_W-1:0]      x_pos;
    logic [POS_W-1:0]      y_pos;
  } placement_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gasc_in_if  glyph_if ();
  gasc_out_if place_if ();

  glyph_atlas_slot_cache_unit #(
    .INDEX_COUNT(INDEX_COUNT),
    .SLOT_COUNT (SLOT_COUNT)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .glyph_i   (glyph_if),
    .place_o   (place_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Bench copy of the slot table, the allocation count and the registers
  bit                 entry_valid [INDEX_COUNT];
  logic [CNT_W-1:0]   entry_slot  [INDEX_COUNT];
  logic [CNT_W-1:0]   cells_used  = '0;
  logic [TEX_W-1:0]   tex_width   = TEX_W_RST;
  logic [CELL_W-1:0]  cell_w      = CELL_W_RST;
  logic [CELL_W-1:0]  cell_h      = CELL_H_RST;
  logic [CNT_W-1:0]   slot_lim    = SLOT_LIM_RST;

  placement_t         placement_q   [$];
  logic [GLYPH_W-1:0] placed_glyphs [$];

  int unsigned errors        = 0;
  int unsigned idle_cycles   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Texel origin of a cell under the current registers
  function automatic placement_t cell_origin(input logic [CNT_W-1:0] slot_no);
    int unsigned per_line;
    int unsigned col;
    int unsigned row;
    placement_t  p;
    per_line = (cell_w != 0) ? int'(tex_width) / int'(cell_w) : 0;
    if (per_line == 0) per_line = 1;
    col = (int'(slot_no) % per_line) * int'(cell_w);
    row = (int'(slot_no) / per_line) * int'(cell_h);
    p = '0;
    p.slot  = slot_no[SLOT_OUT_W-1:0];
    p.x_pos = col[POS_W-1:0];
    p.y_pos = row[POS_W-1:0];
    return p;
  endfunction

  // Look a glyph up, allocating a cell on a miss, and return the expected placement
  function automatic placement_t lookup_glyph(input logic [GLYPH_W-1:0] glyph,
                                              input logic ok);
    int unsigned idx;
    int unsigned limit;
    placement_t  p;
    idx   = int'(glyph) % INDEX_COUNT;
    limit = (slot_lim > SLOT_COUNT) ? SLOT_COUNT : int'(slot_lim);
    p     = '0;
    if (entry_valid[idx]) begin
      p = cell_origin(entry_slot[idx]);
      p.status = ST_HIT;
    end else if (cells_used >= limit) begin
      p.status = ST_FULL;
    end else if (!ok) begin
      p.status = ST_FAIL;
    end else begin
      entry_valid[idx] = 1'b1;
      entry_slot[idx]  = cells_used;
      placed_glyphs.push_back(glyph);
      p = cell_origin(cells_used);
      p.status = ST_NEW;
      cells_used = cells_used + 1'b1;
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    errors++;
  endtask

  // Write one register; only called while nothing is pending
  task automatic write_reg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      REG_TEX_WIDTH:   tex_width = data[TEX_W-1:0];
      REG_CELL_WIDTH:  cell_w    = data[CELL_W-1:0];
      REG_CELL_HEIGHT: cell_h    = data[CELL_W-1:0];
      REG_SLOT_LIMIT:  slot_lim  = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_geometry(input int unsigned tw, input int unsigned cw,
                                input int unsigned ch, input int unsigned lim);
    write_reg(REG_TEX_WIDTH,   CFG_DATA_W'(tw));
    write_reg(REG_CELL_WIDTH,  CFG_DATA_W'(cw));
    write_reg(REG_CELL_HEIGHT, CFG_DATA_W'(ch));
    write_reg(REG_SLOT_LIMIT,  CFG_DATA_W'(lim));
  endtask

  // Offer one lookup, with a random gap first, and log its expected placement on transfer
  task automatic send_glyph(input logic [GLYPH_W-1:0] glyph, input logic ok);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      glyph_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    glyph_if.valid       <= 1'b1;
    glyph_if.glyph_index <= glyph;
    glyph_if.render_ok   <= ok;
    @(posedge clk_i);
    while (!glyph_if.ready) @(posedge clk_i);
    placement_q.push_back(lookup_glyph(glyph, ok));
  endtask

  // Drop valid and wait until every pending placement has come back
  task automatic close_burst();
    glyph_if.valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
  endtask

  // Random lookup: a share of repeats of placed glyphs, the rest fresh numbers
  task automatic send_random_glyph();
    logic [GLYPH_W-1:0] glyph;
    if (placed_glyphs.size() != 0 && $urandom_range(0, 99) < 30)
      glyph = placed_glyphs[$urandom_range(0, placed_glyphs.size() - 1)];
    else
      glyph = GLYPH_W'($urandom_range(0, GLYPH_MAX));
    send_glyph(glyph, $urandom_range(0, 99) < 85);
  endtask

  // Insertions at both ends of the glyph range, hits and a render failure
  task automatic test_insert_and_hit();
    send_glyph(GLYPH_W'(0), 1'b1);
    send_glyph(GLYPH_W'(GLYPH_MAX), 1'b1);
    send_glyph(GLYPH_W'(0), 1'b0);
    send_glyph(GLYPH_W'(100), 1'b0);
    send_glyph(GLYPH_W'(100), 1'b1);
    send_glyph(GLYPH_W'(GLYPH_MAX), 1'b0);
    close_burst();
  endtask

  // Full is reported ahead of a render failure; a limit above capacity is clipped
  task automatic test_full_cache();
    write_reg(REG_SLOT_LIMIT, CFG_DATA_W'(0));
    send_glyph(GLYPH_W'(200), 1'b1);
    send_glyph(GLYPH_W'(201), 1'b0);
    send_glyph(GLYPH_W'(0), 1'b1);
    close_burst();
    write_reg(REG_SLOT_LIMIT, CFG_DATA_W'((1 << CNT_W) - 1));
    send_glyph(GLYPH_W'(300), 1'b1);
    close_burst();
  endtask

  // Zero cells per line, oversized cells and extreme texture widths
  task automatic test_position_edges();
    write_reg(REG_CELL_WIDTH, CFG_DATA_W'(0));
    send_glyph(GLYPH_W'(100), 1'b1);
    close_burst();
    write_reg(REG_CELL_WIDTH, CFG_DATA_W'(300));
    send_glyph(GLYPH_W'(300), 1'b0);
    close_burst();
    write_geometry((1 << TEX_W) - 1, 1, (1 << CELL_W) - 1, SLOT_COUNT);
    send_glyph(GLYPH_W'(GLYPH_MAX), 1'b1);
    send_glyph(GLYPH_W'(300), 1'b1);
    close_burst();
    write_reg(REG_TEX_WIDTH, CFG_DATA_W'(1));
    send_glyph(GLYPH_W'(300), 1'b0);
    close_burst();
    write_geometry((1 << TEX_W) - 1, (1 << CELL_W) - 1, 0, SLOT_COUNT);
    send_glyph(GLYPH_W'(100), 1'b1);
    close_burst();
  endtask

  // Hold the result side off for a long stretch while lookups keep coming
  task automatic test_backpressure();
    write_geometry(TEX_W_RST, CELL_W_RST, CELL_H_RST, SLOT_COUNT);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_glyph();
    hold_req = 1'b1;
    repeat (24) send_random_glyph();
    close_burst();
  endtask

  // Phases of random lookups, each under fresh registers and its own idling mix
  task automatic test_random_traffic();
    int unsigned tw;
    int unsigned cw;
    int unsigned ch;
    int unsigned lim;
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 7;
        recv_idle_pct = 60;
      end else if (phase < 8) begin
        send_idle_pct = 60;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(0, 4))
        0:       tw = 1;
        1:       tw = (1 << TEX_W) - 1;
        2:       tw = 8192;
        default: tw = $urandom_range(16, 4096);
      endcase
      case ($urandom_range(0, 5))
        0:       cw = 0;
        1:       cw = 1;
        2:       cw = (1 << CELL_W) - 1;
        3:       cw = $urandom_range(257, (1 << CELL_W) - 1);
        default: cw = $urandom_range(1, 256);
      endcase
      case ($urandom_range(0, 4))
        0:       ch = 0;
        1:       ch = 1;
        2:       ch = (1 << CELL_W) - 1;
        default: ch = $urandom_range(1, 256);
      endcase
      // In half the phases a little headroom over the current count, so full shows up often
      if (phase == 3)
        lim = 0;
      else if (phase % 4 == 1)
        lim = SLOT_COUNT;
      else if (phase >= 10)
        lim = (1 << CNT_W) - 1;
      else
        lim = int'(cells_used) + $urandom_range(0, 160);
      if (lim > (1 << CNT_W) - 1) lim = (1 << CNT_W) - 1;
      write_geometry(tw, cw, ch, lim);
      repeat (PHASE_ITEMS) send_random_glyph();
      close_burst();
    end
  endtask

  // Result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        place_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        place_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer with the oldest expected placement
  always @(posedge clk_i) begin : check_result
    placement_t want;
    if (rst_ni && place_if.valid && place_if.ready) begin
      if (placement_q.size() == 0) begin
        report_mismatch("unexpected result, status", place_if.status, 0);
      end else begin
        want = placement_q.pop_front();
        if (place_if.status !== want.status)
          report_mismatch("status", place_if.status, want.status);
        if (place_if.slot !== want.slot)
          report_mismatch("slot", place_if.slot, want.slot);
        if (place_if.x_pos !== want.x_pos)
          report_mismatch("x_pos", place_if.x_pos, want.x_pos);
        if (place_if.y_pos !== want.y_pos)
          report_mismatch("y_pos", place_if.y_pos, want.y_pos);
      end
    end
  end

  // Abort when nothing has moved for too long
  always @(posedge clk_i) begin
    if ((glyph_if.valid && glyph_if.ready) || (place_if.valid && place_if.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    glyph_if.valid       <= 1'b0;
    glyph_if.glyph_index <= '0;
    glyph_if.render_ok   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 60;
    test_insert_and_hit();
    test_full_cache();
    test_position_edges();
    test_backpressure();
    test_random_traffic();

    // Leave room for any late or stray result
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && placement_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (placement_q.size() != 0)
        report_mismatch("results still pending", 0, placement_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
